>>> sv/fncc_pkg.sv
// ----------------------------------------------------------------------------
// fncc_pkg
// Shared constants and types of the framed normalized cross-correlation unit.
// ----------------------------------------------------------------------------
package fncc_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int COUNT_BITS_DEFAULT  = 16;

   localparam int ACC_BITS   = 48;
   localparam int CFG_BITS   = 16;
   localparam int OUT_BITS   = 16;
   localparam int WIDE_BITS  = 128;
   localparam int QUOT_BITS  = 15;
   localparam int SQ_BITS    = 2 * QUOT_BITS;

   localparam logic [CFG_BITS-1:0] FRAME_LENGTH_RESET = CFG_BITS'(22050);
   localparam logic [SQ_BITS-1:0]  FULL_SCALE_SQ      = SQ_BITS'(32767 * 32767);

   typedef struct packed {
      logic [ACC_BITS-1:0] cross_sum;
      logic [ACC_BITS-1:0] reference_energy;
      logic [ACC_BITS-1:0] response_energy;
   } frame_type;

endpackage

>>> sv/fncc_if.sv
// ----------------------------------------------------------------------------
// fncc channel interfaces
// Sample pair channel and correlation result channel, valid/ready.
// ----------------------------------------------------------------------------
interface fncc_req_if #(parameter int SAMPLE_BITS = fncc_pkg::SAMPLE_BITS_DEFAULT);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] reference_sample;
   logic signed [SAMPLE_BITS-1:0] response_sample;
   logic                          first_sample;

   modport source (output valid, reference_sample, response_sample, first_sample,
                   input ready);
   modport sink   (input valid, reference_sample, response_sample, first_sample,
                   output ready);
endinterface

interface fncc_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [fncc_pkg::OUT_BITS-1:0]    correlation;

   modport source (output valid, correlation, input ready);
   modport sink   (input valid, correlation, output ready);
endinterface

>>> sv/fncc_front.sv
// ----------------------------------------------------------------------------
// fncc_front
// Accepts sample pairs, accumulates cross and energy sums, counts the frame
// and hands completed frame sums to the queue.
// ----------------------------------------------------------------------------
module fncc_front #(
   parameter int SAMPLE_BITS = fncc_pkg::SAMPLE_BITS_DEFAULT,
   parameter int COUNT_BITS  = fncc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [fncc_pkg::CFG_BITS-1:0] csr_write_data,
   fncc_req_if.sink                      req_ch,
   output logic                          push_valid,
   input  logic                          push_ready,
   output fncc_pkg::frame_type           push_data
);

   localparam int PROD_BITS = 2 * SAMPLE_BITS;

   logic [fncc_pkg::CFG_BITS-1:0]       frame_length_ff;
   logic [fncc_pkg::ACC_BITS-1:0]       cross_ff, cross_in;
   logic [fncc_pkg::ACC_BITS-1:0]       ref_e_ff, ref_e_in;
   logic [fncc_pkg::ACC_BITS-1:0]       rsp_e_ff, rsp_e_in;
   logic [COUNT_BITS-1:0]               pairs_ff, pairs_in;

   logic signed [PROD_BITS-1:0]         prod_ab, prod_aa, prod_bb;
   logic [fncc_pkg::ACC_BITS-1:0]       sum_cross, sum_ref, sum_rsp;
   logic [COUNT_BITS+fncc_pkg::CFG_BITS-1:0] fl_ext;
   logic [COUNT_BITS-1:0]               len_bits;
   logic [COUNT_BITS:0]                 len, count;
   logic                                accept, frame_end;

   assign req_ch.ready = push_ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign prod_ab = req_ch.reference_sample * req_ch.response_sample;
   assign prod_aa = req_ch.reference_sample * req_ch.reference_sample;
   assign prod_bb = req_ch.response_sample * req_ch.response_sample;

   assign fl_ext   = {{COUNT_BITS{1'b0}}, frame_length_ff};
   assign len_bits = fl_ext[COUNT_BITS-1:0];
   assign len      = (len_bits == '0) ? {1'b1, {COUNT_BITS{1'b0}}} : {1'b0, len_bits};

   always_comb begin
      if (req_ch.first_sample) begin
         sum_cross = fncc_pkg::ACC_BITS'(prod_ab);
         sum_ref   = fncc_pkg::ACC_BITS'(prod_aa);
         sum_rsp   = fncc_pkg::ACC_BITS'(prod_bb);
         count     = (COUNT_BITS+1)'(1);
      end else begin
         sum_cross = cross_ff + fncc_pkg::ACC_BITS'(prod_ab);
         sum_ref   = ref_e_ff + fncc_pkg::ACC_BITS'(prod_aa);
         sum_rsp   = rsp_e_ff + fncc_pkg::ACC_BITS'(prod_bb);
         count     = {1'b0, pairs_ff} + (COUNT_BITS+1)'(1);
      end
      frame_end = (count >= len);
   end

   always_comb begin
      cross_in = cross_ff;
      ref_e_in = ref_e_ff;
      rsp_e_in = rsp_e_ff;
      pairs_in = pairs_ff;
      if (accept) begin
         if (frame_end) begin
            cross_in = '0;
            ref_e_in = '0;
            rsp_e_in = '0;
            pairs_in = '0;
         end else begin
            cross_in = sum_cross;
            ref_e_in = sum_ref;
            rsp_e_in = sum_rsp;
            pairs_in = count[COUNT_BITS-1:0];
         end
      end
   end

   assign push_valid                 = accept && frame_end;
   assign push_data.cross_sum        = sum_cross;
   assign push_data.reference_energy = sum_ref;
   assign push_data.response_energy  = sum_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff <= fncc_pkg::FRAME_LENGTH_RESET;
         cross_ff        <= '0;
         ref_e_ff        <= '0;
         rsp_e_ff        <= '0;
         pairs_ff        <= '0;
      end else begin
         if (csr_write_enable) begin
            frame_length_ff <= csr_write_data;
         end
         cross_ff <= cross_in;
         ref_e_ff <= ref_e_in;
         rsp_e_ff <= rsp_e_in;
         pairs_ff <= pairs_in;
      end
   end

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> push_ready) else $error("frame pushed into full queue");

   a_count_advance: assert property (@(posedge clock) disable iff (reset)
      (accept && !frame_end) |=> (pairs_ff != '0))
      else $error("pair count not advanced inside frame");

   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      push_valid |=> (pairs_ff == '0 && cross_ff == '0))
      else $error("sums not cleared after frame end");

endmodule

>>> sv/fncc_queue.sv
// ----------------------------------------------------------------------------
// fncc_queue
// Two-entry queue of completed frame sums between front and back.
// ----------------------------------------------------------------------------
module fncc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  fncc_pkg::frame_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output fncc_pkg::frame_type pop_data
);

   fncc_pkg::frame_type entry_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;
   logic                push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("queue pointers disagree with count");

   a_ptr_full_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff != 2'd1) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

>>> sv/fncc_back.sv
// ----------------------------------------------------------------------------
// fncc_back
// Turns frame sums into the scaled correlation: shift-add multiplier for
// S*R, |x|^2 and the full-scale bound, then a 15-step restoring search.
// ----------------------------------------------------------------------------
module fncc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  fncc_pkg::frame_type pop_data,
   fncc_rsp_if.source          rsp_ch
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MSR  = 3'd1;
   localparam logic [2:0] S_MM   = 3'd2;
   localparam logic [2:0] S_ML   = 3'd3;
   localparam logic [2:0] S_MT   = 3'd4;

   localparam int W  = fncc_pkg::WIDE_BITS;
   localparam int AB = fncc_pkg::ACC_BITS;
   localparam int QB = fncc_pkg::QUOT_BITS;
   localparam int OB = fncc_pkg::OUT_BITS;

   logic [2:0]        state_ff, state_in;
   logic [W-1:0]      mul_a_ff, mul_a_in;
   logic [AB-1:0]     mul_b_ff, mul_b_in;
   logic [W-1:0]      mul_acc_ff, mul_acc_in;
   logic [W-1:0]      sr_ff, sr_in;
   logic [W-1:0]      lim_ff, lim_in;
   logic [AB-1:0]     mag_ff, mag_in;
   logic              neg_ff, neg_in;
   logic [QB-1:0]     q_ff, q_in;
   logic [3:0]        bit_ff, bit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OB-1:0]     corr_ff, corr_in;

   logic              pop;
   logic              mul_done;
   logic [QB-1:0]     t_cur, t_next, q_upd;
   logic [3:0]        bit_next;
   logic [fncc_pkg::SQ_BITS-1:0] tt_next;
   logic [AB-1:0]     neg_cross;

   assign pop_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign pop       = pop_valid && pop_ready;
   assign mul_done  = (mul_b_ff == '0);
   assign neg_cross = '0 - pop_data.cross_sum;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.correlation = corr_ff;

   always_comb begin
      t_cur    = q_ff | (QB'(1) << bit_ff);
      q_upd    = (mul_acc_ff <= lim_ff) ? t_cur : q_ff;
      bit_next = bit_ff - 4'd1;
      t_next   = q_upd | (QB'(1) << bit_next);
      tt_next  = t_next * t_next;
   end

   always_comb begin
      state_in     = state_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      mul_acc_in   = mul_acc_ff;
      sr_in        = sr_ff;
      lim_in       = lim_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      q_in         = q_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff;
      corr_in      = corr_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (state_ff != S_IDLE && !mul_done) begin
         if (mul_b_ff[0]) begin
            mul_acc_in = mul_acc_ff + mul_a_ff;
         end
         mul_a_in = {mul_a_ff[W-2:0], 1'b0};
         mul_b_in = {1'b0, mul_b_ff[AB-1:1]};
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (pop) begin
                  neg_in = pop_data.cross_sum[AB-1];
                  mag_in = pop_data.cross_sum[AB-1] ? neg_cross : pop_data.cross_sum;
                  if (pop_data.reference_energy == '0 || pop_data.response_energy == '0) begin
                     rsp_valid_in = 1'b1;
                     corr_in      = '0;
                  end else begin
                     mul_a_in   = W'(pop_data.reference_energy);
                     mul_b_in   = pop_data.response_energy;
                     mul_acc_in = '0;
                     state_in   = S_MSR;
                  end
               end
            end
            S_MSR: begin
               sr_in      = mul_acc_ff;
               mul_a_in   = W'(mag_ff);
               mul_b_in   = mag_ff;
               mul_acc_in = '0;
               state_in   = S_MM;
            end
            S_MM: begin
               mul_a_in   = mul_acc_ff;
               mul_b_in   = AB'(fncc_pkg::FULL_SCALE_SQ);
               mul_acc_in = '0;
               state_in   = S_ML;
            end
            S_ML: begin
               lim_in     = mul_acc_ff;
               q_in       = '0;
               bit_in     = 4'(QB - 1);
               mul_a_in   = sr_ff;
               mul_b_in   = AB'(fncc_pkg::SQ_BITS'(1 << (2 * (QB - 1))));
               mul_acc_in = '0;
               state_in   = S_MT;
            end
            S_MT: begin
               q_in = q_upd;
               if (bit_ff == 4'd0) begin
                  rsp_valid_in = 1'b1;
                  corr_in      = neg_ff ? ('0 - OB'(q_upd)) : OB'(q_upd);
                  state_in     = S_IDLE;
               end else begin
                  bit_in     = bit_next;
                  mul_a_in   = sr_ff;
                  mul_b_in   = AB'(tt_next);
                  mul_acc_in = '0;
               end
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      mul_a_ff   <= mul_a_in;
      mul_b_ff   <= mul_b_in;
      mul_acc_ff <= mul_acc_in;
      sr_ff      <= sr_in;
      lim_ff     <= lim_in;
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      q_ff       <= q_in;
      bit_ff     <= bit_in;
      corr_ff    <= corr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_pop_slot_free: assert property (@(posedge clock) disable iff (reset)
      pop |-> !rsp_valid_ff) else $error("frame taken while result slot busy");

   a_pop_progress: assert property (@(posedge clock) disable iff (reset)
      pop |=> (state_ff != S_IDLE || rsp_valid_ff))
      else $error("frame dropped after pop");

   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MT) |-> (bit_ff <= 4'(QB - 1)))
      else $error("search bit index out of range");

   a_no_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !rsp_valid_ff)
      else $error("result pending during computation");

endmodule

>>> sv/framed_normalized_cross_correlation_unit.sv
// Path: a frame with a zero energy sum gets a zero result without any multiply; otherwise
//   the serial multiplier forms R*S, |x|^2 and the full-scale bound, then runs 15 search
//   steps of one multiply each, from the last pair of a frame to its result.
// Throughput: one sample pair per cycle while the queue has room; one result per frame, frames back to back
//   limited by the back end's serial multiplier, which takes a new frame only when idle with no result pending.
// Reset: clears the sums, pair count and queue; frame_length returns to 22050.
// ----------------------------------------------------------------------------
// framed_normalized_cross_correlation_unit
// Framed zero-lag normalized cross-correlation, scaled by 32767.
// ----------------------------------------------------------------------------
module framed_normalized_cross_correlation_unit #(
   parameter int SAMPLE_BITS = fncc_pkg::SAMPLE_BITS_DEFAULT,
   parameter int COUNT_BITS  = fncc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [fncc_pkg::CFG_BITS-1:0] csr_write_data,
   fncc_req_if.sink                      req_ch,
   fncc_rsp_if.source                    rsp_ch
);

   logic                push_valid, push_ready;
   logic                pop_valid, pop_ready;
   fncc_pkg::frame_type push_data, pop_data;

   fncc_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_ch           (req_ch),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_data        (push_data)
   );

   fncc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   fncc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_ch    (rsp_ch)
   );

endmodule

>>> tb/sv/framed_normalized_cross_correlation_unit_test.sv
// ----------------------------------------------------------------------------
// framed_normalized_cross_correlation_unit_test
// Drives sample pairs with random gaps and response stalls, predicts each
// frame's normalized correlation exactly and checks every result in order.
// ----------------------------------------------------------------------------
module framed_normalized_cross_correlation_unit_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 5000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [fncc_pkg::CFG_BITS-1:0] csr_write_data = '0;

   fncc_req_if req_ch ();
   fncc_rsp_if rsp_ch ();

   framed_normalized_cross_correlation_unit dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_ch(req_ch), .rsp_ch(rsp_ch)
   );

   always #1 clock = ~clock;

   logic [fncc_pkg::CFG_BITS-1:0] frame_len;
   logic [fncc_pkg::ACC_BITS-1:0] xsum, esum_ref, esum_rsp;
   int unsigned pair_count;
   logic signed [fncc_pkg::OUT_BITS-1:0] expected_corr[$];
   int errors = 0;
   int results_seen = 0;
   int items_sent = 0;
   longint cycles = 0;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.reference_sample = '0;
      req_ch.response_sample = '0;
      req_ch.first_sample = 1'b0;
      rsp_ch.ready = 1'b0;
   end

   function automatic logic [fncc_pkg::OUT_BITS-1:0] normalized_corr();
      logic neg;
      logic [fncc_pkg::ACC_BITS-1:0] mag;
      logic [fncc_pkg::WIDE_BITS-1:0] sr, lim, t;
      logic [fncc_pkg::QUOT_BITS-1:0] q, c;
      neg = xsum[fncc_pkg::ACC_BITS-1];
      mag = neg ? -xsum : xsum;
      q = '0;
      if (esum_ref == 0 || esum_rsp == 0) return '0;
      sr = fncc_pkg::WIDE_BITS'(esum_ref) * fncc_pkg::WIDE_BITS'(esum_rsp);
      lim = fncc_pkg::WIDE_BITS'(mag) * fncc_pkg::WIDE_BITS'(mag)
            * fncc_pkg::WIDE_BITS'(32767 * 32767);
      for (int b = fncc_pkg::QUOT_BITS - 1; b >= 0; b--) begin
         c = q | (fncc_pkg::QUOT_BITS'(1) << b);
         t = sr * (fncc_pkg::WIDE_BITS'(c) * fncc_pkg::WIDE_BITS'(c));
         if (t <= lim) q = c;
      end
      return neg ? -{1'b0, q} : {1'b0, q};
   endfunction

   task automatic clear_frame();
      xsum = '0;
      esum_ref = '0;
      esum_rsp = '0;
      pair_count = 0;
   endtask

   task automatic accumulate_pair(logic signed [15:0] a, logic signed [15:0] b, logic first);
      int unsigned len;
      len = (frame_len == 0) ? 65536 : frame_len;
      if (first) clear_frame();
      xsum = xsum + fncc_pkg::ACC_BITS'(longint'(a) * longint'(b));
      esum_ref = esum_ref + fncc_pkg::ACC_BITS'(longint'(a) * longint'(a));
      esum_rsp = esum_rsp + fncc_pkg::ACC_BITS'(longint'(b) * longint'(b));
      if (pair_count + 1 >= len) begin
         expected_corr.push_back(normalized_corr());
         clear_frame();
      end else begin
         pair_count = pair_count + 1;
      end
   endtask

   task automatic send_pair(logic signed [15:0] a, logic signed [15:0] b, logic first);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.reference_sample <= a;
      req_ch.response_sample <= b;
      req_ch.first_sample <= first;
      do @(posedge clock); while (!req_ch.ready);
      accumulate_pair(a, b, first);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_corr.size() != 0) @(posedge clock);
      repeat (700) @(posedge clock);
   endtask

   task automatic write_frame_length(logic [fncc_pkg::CFG_BITS-1:0] len);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data <= len;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      frame_len = len;
   endtask

   function automatic logic signed [15:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'(int'($urandom_range(0, 16)) - 8);
         default: return 16'($urandom);
      endcase
   endfunction

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (expected_corr.size() == 0) begin
            $error("correlation: no result expected, actual %0d", rsp_ch.correlation);
            errors++;
         end else begin
            if (rsp_ch.correlation !== expected_corr[0]) begin
               $error("correlation: expected %0d actual %0d", expected_corr[0],
                      rsp_ch.correlation);
               errors++;
            end
            void'(expected_corr.pop_front());
         end
      end
   end

   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   task automatic test_directed();
      write_frame_length(4);
      send_pair(16'sh7fff, 16'sh7fff, 1'b1);
      send_pair(16'sh8000, 16'sh8000, 1'b0);
      send_pair(16'sh7fff, 16'sh8000, 1'b0);
      send_pair(16'sh8000, 16'sh7fff, 1'b0);
      send_pair(16'sh7fff, 16'sh8001, 1'b0);
      send_pair(16'sh8000, 16'sh7fff, 1'b0);
      send_pair(16'sh1234, 16'shedcc, 1'b0);
      send_pair(16'sh0001, 16'shffff, 1'b0);
      // zero energy on one side
      send_pair(16'sh0000, 16'sh5555, 1'b0);
      send_pair(16'sh0000, 16'shaaaa, 1'b0);
      send_pair(16'sh0000, 16'sh0001, 1'b0);
      send_pair(16'sh0000, 16'sh7fff, 1'b0);
      // restart discards partial frame
      send_pair(16'sh4000, 16'sh2000, 1'b0);
      send_pair(16'sh4000, 16'shc000, 1'b1);
      send_pair(16'sh0003, 16'sh0005, 1'b0);
      send_pair(16'shfffd, 16'sh0007, 1'b0);
      send_pair(16'sh0100, 16'sh00ff, 1'b0);
      write_frame_length(1);
      send_pair(16'sh7fff, 16'sh8000, 1'b0);
      send_pair(16'sh0000, 16'sh0000, 1'b1);
      // lowering the length mid-frame ends it on the next pair
      write_frame_length(6);
      send_pair(16'sh0101, 16'sh0202, 1'b0);
      send_pair(16'sh0303, 16'shfefe, 1'b0);
      send_pair(16'sh0011, 16'sh0022, 1'b0);
      write_frame_length(2);
      send_pair(16'sh0044, 16'sh0033, 1'b0);
   endtask

   task automatic test_random(int n, int max_len);
      write_frame_length(fncc_pkg::CFG_BITS'($urandom_range(1, max_len)));
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 150) == 0) begin
            write_frame_length(fncc_pkg::CFG_BITS'($urandom_range(1, max_len)));
         end
         send_pair(rand_sample(), rand_sample(), $urandom_range(0, 40) == 0);
      end
   endtask

   initial begin
      frame_len = fncc_pkg::FRAME_LENGTH_RESET;
      clear_frame();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1000, 12);
      test_random(250, 60);
      write_frame_length(3);
      wait_drained();
      $display("Sent %0d sample pairs; checked %0d correlation results", items_sent,
               results_seen);
      $display("Short frame lengths, mid-frame length changes, restarts, zero energy");
      if (errors == 0 && expected_corr.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
